// File: rtl/usw_pkg.sv
// Shared types and constants for the uniform square window detector.
// Used by the top level; depends on nothing.

package usw_pkg;

  localparam int VALUE_W    = 32;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'd1;

  localparam logic [SIZE_W-1:0] WINDOW_SIZE_RST = 5'd5;
  localparam logic [SIZE_W-1:0] ROW_WIDTH_RST   = 5'd10;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [VALUE_W-1:0] value;
  } row_entry_t;

endpackage

// File: rtl/uniform_square_window_detect.sv
// Uniform square window detector: one matrix cell per cycle unless stalled, result on the last cell.
// A taken last cell is held in the compute stage, then its result is registered in the output register.
// Throughput: one cell per cycle; a last cell, and the cells behind it, wait only while an earlier result is untaken.
// The row buffer RAM is read when a cell is taken and written back when that cell leaves the compute stage.
// Reset returns all control state to its defaults; the row buffer holds no reset and needs no clearing.
// Depends on usw_pkg and usw_ram.

module uniform_square_window_detect #(
  parameter int MAX_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [usw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [usw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [usw_pkg::VALUE_W-1:0]        s_axis_tdata,  // [31:0] cell_value
  input  logic                               s_axis_tlast,  // last_cell
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [usw_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // [0] square_found, rest zero
);

  import usw_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = ((COL_W + 1) > SIZE_W) ? (COL_W + 1) : SIZE_W;
  localparam int ENTRY_W = $bits(row_entry_t);

  logic [SIZE_W-1:0]  window_size_q;
  logic [SIZE_W-1:0]  row_width_q;

  logic [COL_W-1:0]   col_q, col_d;
  logic               first_row_q, first_row_d;

  logic               s1_valid_q, s1_valid_d;
  logic [VALUE_W-1:0] s1_value_q;
  logic               s1_last_q;
  logic [COL_W-1:0]   s1_col_q;
  logic               s1_first_q;

  logic [VALUE_W-1:0] left_value_q, left_value_d;
  logic [SIZE_W-1:0]  left_size_q, left_size_d;
  logic [VALUE_W-1:0] diag_value_q, diag_value_d;
  logic [SIZE_W-1:0]  diag_size_q, diag_size_d;
  logic               found_q, found_d;

  logic               fwd_q;
  row_entry_t         fwd_entry_q;

  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;

  logic               s_accept;
  logic               s1_stall;
  logic               s1_fire;
  logic [CNT_W-1:0]   width_eff;
  logic [CNT_W-1:0]   col_inc;
  logic [SIZE_W-1:0]  win_eff;
  logic [ENTRY_W-1:0] ram_rdata;
  row_entry_t         upper;
  row_entry_t         wr_entry;
  logic               match;
  logic [SIZE_W-1:0]  min_size;
  logic [SIZE_W:0]    size_raw;
  logic [SIZE_W-1:0]  size_new;
  logic               hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RST;
      row_width_q   <= ROW_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_SIZE: window_size_q <= cfg_data_i;
        REG_ROW_WIDTH:   row_width_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_stall      = s1_valid_q && s1_last_q && out_valid_q && !m_axis_tready;
  assign s1_fire       = s1_valid_q && !s1_stall;
  assign s_axis_tready = !s1_stall;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (row_width_q == '0) begin
      width_eff = CNT_W'(1);
    end else if (CNT_W'(row_width_q) > CNT_W'(MAX_WIDTH)) begin
      width_eff = CNT_W'(MAX_WIDTH);
    end else begin
      width_eff = CNT_W'(row_width_q);
    end
    col_inc = CNT_W'(col_q) + CNT_W'(1);
    col_d       = col_q;
    first_row_d = first_row_q;
    if (s_accept) begin
      if (s_axis_tlast) begin
        col_d       = '0;
        first_row_d = 1'b1;
      end else if (col_inc >= width_eff) begin
        col_d       = '0;
        first_row_d = 1'b0;
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  usw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (wr_entry),
    .re_i    (s_accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    win_eff  = (window_size_q == '0) ? SIZE_W'(1) : window_size_q;
    upper    = fwd_q ? fwd_entry_q : row_entry_t'(ram_rdata);
    match    = !s1_first_q && (s1_col_q != '0) && (s1_value_q == left_value_q) &&
               (s1_value_q == upper.value) && (s1_value_q == diag_value_q);
    min_size = (left_size_q < upper.size) ? left_size_q : upper.size;
    min_size = (min_size < diag_size_q) ? min_size : diag_size_q;
    size_raw = match ? ({1'b0, min_size} + (SIZE_W+1)'(1)) : (SIZE_W+1)'(1);
    size_new = (size_raw > {1'b0, win_eff}) ? win_eff : size_raw[SIZE_W-1:0];
    hit      = size_new >= win_eff;
    wr_entry.value = s1_value_q;
    wr_entry.size  = size_new;

    left_value_d = left_value_q;
    left_size_d  = left_size_q;
    diag_value_d = diag_value_q;
    diag_size_d  = diag_size_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_found_d  = out_found_q;
    s1_valid_d   = s_accept || (s1_valid_q && !s1_fire);
    if (s1_fire) begin
      if (s1_last_q) begin
        out_valid_d  = 1'b1;
        out_found_d  = found_q || hit;
        found_d      = 1'b0;
        left_value_d = '0;
        left_size_d  = '0;
        diag_value_d = '0;
        diag_size_d  = '0;
      end else begin
        found_d      = found_q || hit;
        left_value_d = s1_value_q;
        left_size_d  = size_new;
        diag_value_d = upper.value;
        diag_size_d  = upper.size;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      first_row_q  <= 1'b1;
      s1_valid_q   <= 1'b0;
      left_value_q <= '0;
      left_size_q  <= '0;
      diag_value_q <= '0;
      diag_size_q  <= '0;
      found_q      <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
    end else begin
      col_q        <= col_d;
      first_row_q  <= first_row_d;
      s1_valid_q   <= s1_valid_d;
      left_value_q <= left_value_d;
      left_size_q  <= left_size_d;
      diag_value_q <= diag_value_d;
      diag_size_q  <= diag_size_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
      out_found_q  <= out_found_d;
      if (s_accept) begin
        fwd_q <= s1_fire && (s1_col_q == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_value_q  <= s_axis_tdata;
      s1_last_q   <= s_axis_tlast;
      s1_col_q    <= col_q;
      s1_first_q  <= first_row_q;
      fwd_entry_q <= wr_entry;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_found_q);

  a_fwd_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(s_accept && s1_fire))
    else $error("row buffer bypass set without a same-cycle write and read");

  a_stage_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(s_accept || s1_stall))
    else $error("compute stage holds a cell that was never taken");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_last_q))
    else $error("result raised without a last cell");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |-> (!out_valid_q || m_axis_tready))
    else $error("pending result overwritten");

endmodule

// File: rtl/usw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; instantiated by the top level as the row buffer.

module usw_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
